>>> sv/pcla_pkg.sv
// ----------------------------------------------------------------------------
// pcla_pkg: shared types and constants of the line and arc interpolator
// Field widths, motion and request kind codes, and the queued request layout.
// ----------------------------------------------------------------------------
package pcla_pkg;

  // Default width of the tool position registers.
  localparam int COORD_BITS = 16;

  // Width of a segment delta, one bit wider than a 16-bit coordinate.
  localparam int DELTA_BITS = 17;

  // Depth of the queue between the front and the interpolation core.
  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;

  // Request kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Motion codes.
  localparam logic [1:0] MOT_NONE = 2'd0;
  localparam logic [1:0] MOT_LINE = 2'd1;
  localparam logic [1:0] MOT_CW   = 2'd2;
  localparam logic [1:0] MOT_CCW  = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [1:0]         motion;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] center_dx;
    logic signed [15:0] center_dy;
    logic [14:0]        radius;
  } item_t;

endpackage

>>> sv/pcla_front.sv
// ----------------------------------------------------------------------------
// pcla_front: request intake and classification
// Unpacks each request, folds segments with nothing to do into no motion and
// holds the result in a short queue for the interpolation core.
// ----------------------------------------------------------------------------
module pcla_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pcla_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  output logic                            q_valid,
  output pcla_pkg::item_t                 q_item,
  input  logic                            q_pop
);

  localparam int DEPTH = pcla_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  pcla_pkg::item_t entry [DEPTH];
  pcla_pkg::item_t item_in;
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;

  always_comb begin
    item_in.kind      = s_tuser;
    item_in.motion    = s_tdata[1:0];
    item_in.start_x   = s_tdata[17:2];
    item_in.start_y   = s_tdata[33:18];
    item_in.end_x     = s_tdata[49:34];
    item_in.end_y     = s_tdata[65:50];
    item_in.center_dx = s_tdata[81:66];
    item_in.center_dy = s_tdata[97:82];
    item_in.radius    = s_tdata[112:98];
    // A line that goes nowhere, or an arc without radius, is no motion.
    if (s_tdata[1:0] == pcla_pkg::MOT_LINE && s_tdata[17:2] == s_tdata[49:34] &&
        s_tdata[33:18] == s_tdata[65:50]) begin
      item_in.motion = pcla_pkg::MOT_NONE;
    end
    if ((s_tdata[1:0] == pcla_pkg::MOT_CW || s_tdata[1:0] == pcla_pkg::MOT_CCW) &&
        s_tdata[112:98] == '0) begin
      item_in.motion = pcla_pkg::MOT_NONE;
    end
  end

  assign s_tready = (count != CW'(DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !q_pop) begin
        count <= count + CW'(1);
      end else if (q_pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> sv/pcla_back.sv
// ----------------------------------------------------------------------------
// pcla_back: interpolation core
// Latches segments, sets up the deviation from the tool position with a short
// multiply sequence, then steps the tool once per tick with incremental
// deviation updates, and holds each result in an output register.
// ----------------------------------------------------------------------------
module pcla_back #(
  parameter int COORD_BITS = pcla_pkg::COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  pcla_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pcla_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);

  localparam int C  = COORD_BITS;
  localparam int W  = ((C > 17) ? C : 17) + 1;
  localparam int FW = 2 * W + 2;
  localparam int XW = (C > 16) ? C : 16;
  localparam int DW = pcla_pkg::DELTA_BITS;

  localparam logic signed [C-1:0] CMAX = {1'b0, {(C - 1){1'b1}}};
  localparam logic signed [C-1:0] CMIN = {1'b1, {(C - 1){1'b0}}};

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DIFF = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  localparam logic [1:0] Q1 = 2'd0;
  localparam logic [1:0] Q2 = 2'd1;
  localparam logic [1:0] Q3 = 2'd2;
  localparam logic [1:0] Q4 = 2'd3;

  // Control state.
  logic [1:0]          state;
  logic [1:0]          seg_motion;
  logic                pending;
  logic [1:0]          quad;
  logic signed [C-1:0] tool_x;
  logic signed [C-1:0] tool_y;

  // Segment geometry.
  logic signed [W-1:0]    ref_x;
  logic signed [W-1:0]    ref_y;
  logic signed [W-1:0]    end_x;
  logic signed [W-1:0]    end_y;
  logic signed [W-1:0]    xpr;
  logic signed [W-1:0]    xmr;
  logic signed [W-1:0]    ypr;
  logic signed [W-1:0]    ymr;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic signed [15:0]     ci;
  logic signed [15:0]     cj;
  logic [14:0]            r;

  // Deviation and its offsets.
  logic signed [W-1:0]    u;
  logic signed [W-1:0]    v;
  logic signed [FW-1:0]   f;
  logic signed [2*W-1:0]  p1;
  logic signed [2*W-1:0]  p2;
  logic [29:0]            p3;

  pcla_pkg::item_t        it;
  logic                   is_tick;
  logic                   out_free;
  logic                   take_load;
  logic                   take_tick;
  logic                   arc;
  logic                   cw;

  logic                   mx_en, mx_neg, my_en, my_neg;
  logic                   f_neg, f_zero, f_pos;
  logic                   q_hit;
  logic [1:0]             q_first;
  logic [1:0]             q_cur;
  logic [1:0]             q_after;
  logic signed [1:0]      step_x;
  logic signed [1:0]      step_y;
  logic signed [C-1:0]    tool_x_next;
  logic signed [C-1:0]    tool_y_next;
  logic signed [W-1:0]    nx;
  logic signed [W-1:0]    ny;
  logic signed [W-1:0]    base;
  logic signed [FW-1:0]   b2;
  logic signed [FW-1:0]   addend;
  logic                   wrap;
  logic                   done;
  logic [XW-1:0]          pos_x_ext;
  logic [XW-1:0]          pos_y_ext;
  logic signed [W-1:0]    mul_a, mul_b, mul_c, mul_d;
  logic signed [W-1:0]    ld_sx, ld_sy, ld_cx, ld_cy, ld_r;

  assign it        = q_item;
  assign is_tick   = (it.kind == pcla_pkg::KIND_TICK);
  assign out_free  = !m_tvalid || m_tready;
  assign take_load = q_valid && !is_tick;
  assign take_tick = q_valid && is_tick && (state == ST_RUN) && out_free;
  assign q_pop     = take_load || take_tick;

  assign arc = (seg_motion == pcla_pkg::MOT_CW) || (seg_motion == pcla_pkg::MOT_CCW);
  assign cw  = (seg_motion == pcla_pkg::MOT_CW);

  // Quadrant of the first tick, from the signs of the centre offset.
  always_comb begin
    logic ci_neg, ci_pos, cj_neg, cj_pos;
    ci_neg  = ci[15];
    ci_pos  = !ci[15] && (ci != '0);
    cj_neg  = cj[15];
    cj_pos  = !cj[15] && (cj != '0);
    q_hit   = 1'b1;
    q_first = Q1;
    if (cw) begin
      if (!ci_pos && cj_neg)       q_first = Q1;
      else if (ci_pos && !cj_pos)  q_first = Q2;
      else if (!ci_neg && cj_pos)  q_first = Q3;
      else if (ci_neg && !cj_neg)  q_first = Q4;
      else                         q_hit   = 1'b0;
    end else begin
      if (ci_neg && !cj_pos)       q_first = Q1;
      else if (!ci_neg && cj_neg)  q_first = Q2;
      else if (ci_pos && !cj_neg)  q_first = Q3;
      else if (!ci_pos && cj_pos)  q_first = Q4;
      else                         q_hit   = 1'b0;
    end
  end

  assign q_cur  = (arc && pending && q_hit) ? q_first : quad;
  assign f_neg  = f[FW-1];
  assign f_zero = (f == '0);
  assign f_pos  = !f_neg && !f_zero;

  // Step direction.
  always_comb begin
    logic dx_pos, dx_neg, dy_pos, dy_neg;
    dx_neg = dx[DW-1];
    dx_pos = !dx[DW-1] && (dx != '0);
    dy_neg = dy[DW-1];
    dy_pos = !dy[DW-1] && (dy != '0);
    mx_en  = 1'b0;
    mx_neg = 1'b0;
    my_en  = 1'b0;
    my_neg = 1'b0;
    unique case (seg_motion)
      pcla_pkg::MOT_NONE: begin
      end
      pcla_pkg::MOT_LINE: begin
        if (dx_pos && !dy_neg) begin
          if (!f_neg) mx_en = 1'b1;
          else        my_en = 1'b1;
        end else if (!dx_pos && dy_pos) begin
          if (!f_neg) my_en = 1'b1;
          else        {mx_en, mx_neg} = 2'b11;
        end else if (dx_neg && !dy_pos) begin
          if (!f_neg) {mx_en, mx_neg} = 2'b11;
          else        {my_en, my_neg} = 2'b11;
        end else begin
          if (!f_pos) mx_en = 1'b1;
          else        {my_en, my_neg} = 2'b11;
        end
      end
      pcla_pkg::MOT_CW: begin
        case (q_cur)
          Q1:      if (f_pos) {my_en, my_neg} = 2'b11; else mx_en = 1'b1;
          Q2:      if (f_pos) mx_en = 1'b1;            else my_en = 1'b1;
          Q3:      if (f_pos) my_en = 1'b1;            else {mx_en, mx_neg} = 2'b11;
          default: if (f_pos) {mx_en, mx_neg} = 2'b11; else {my_en, my_neg} = 2'b11;
        endcase
      end
      default: begin
        case (q_cur)
          Q1:      if (f_pos) {mx_en, mx_neg} = 2'b11; else my_en = 1'b1;
          Q2:      if (f_pos) {my_en, my_neg} = 2'b11; else {mx_en, mx_neg} = 2'b11;
          Q3:      if (f_pos) mx_en = 1'b1;            else {my_en, my_neg} = 2'b11;
          default: if (f_pos) my_en = 1'b1;            else mx_en = 1'b1;
        endcase
      end
    endcase
  end

  assign step_x = mx_en ? (mx_neg ? 2'sb11 : 2'sb01) : 2'sb00;
  assign step_y = my_en ? (my_neg ? 2'sb11 : 2'sb01) : 2'sb00;

  assign tool_x_next = tool_x + C'(step_x);
  assign tool_y_next = tool_y + C'(step_y);
  assign nx = W'(tool_x_next);
  assign ny = W'(tool_y_next);

  // A step across the end of the coordinate range breaks the incremental
  // deviation, so the core sets it up again from the wrapped position.
  assign wrap = (mx_en && (mx_neg ? (tool_x == CMIN) : (tool_x == CMAX))) ||
                (my_en && (my_neg ? (tool_y == CMIN) : (tool_y == CMAX)));

  // Deviation change for one step.
  always_comb begin
    base   = mx_en ? u : v;
    b2     = FW'(base) <<< 1;
    addend = '0;
    if (arc) begin
      if (mx_en ? mx_neg : my_neg) addend = FW'(1) - b2;
      else                         addend = b2 + FW'(1);
    end else if (mx_en) begin
      addend = mx_neg ? FW'(dy) : -FW'(dy);
    end else if (my_en) begin
      addend = my_neg ? -FW'(dx) : FW'(dx);
    end
  end

  // Quadrant change when the tool lands on an axis of the circle.
  always_comb begin
    q_after = q_cur;
    if (cw) begin
      case (q_cur)
        Q1:      if (nx == xpr && ny == ref_y) q_after = Q4;
        Q2:      if (nx == ref_x && ny == ypr) q_after = Q1;
        Q3:      if (nx == xmr && ny == ref_y) q_after = Q2;
        default: if (nx == ref_x && ny == ymr) q_after = Q3;
      endcase
    end else begin
      case (q_cur)
        Q1:      if (nx == ref_x && ny == ypr) q_after = Q2;
        Q2:      if (nx == xmr && ny == ref_y) q_after = Q3;
        Q3:      if (nx == ref_x && ny == ymr) q_after = Q4;
        default: if (nx == xpr && ny == ref_y) q_after = Q1;
      endcase
    end
  end

  assign done = (seg_motion == pcla_pkg::MOT_NONE) || (nx == end_x && ny == end_y);

  assign pos_x_ext = XW'(unsigned'(tool_x_next));
  assign pos_y_ext = XW'(unsigned'(tool_y_next));

  // Operands of the set-up multiplies: squares for an arc, cross terms for a line.
  assign mul_a = arc ? u : W'(dx);
  assign mul_b = arc ? u : v;
  assign mul_c = arc ? v : W'(dy);
  assign mul_d = arc ? v : u;

  assign ld_sx = W'(it.start_x);
  assign ld_sy = W'(it.start_y);
  assign ld_cx = ld_sx + W'(it.center_dx);
  assign ld_cy = ld_sy + W'(it.center_dy);
  assign ld_r  = signed'(W'(it.radius));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      seg_motion <= pcla_pkg::MOT_NONE;
      pending    <= 1'b1;
      quad       <= Q1;
      tool_x     <= '0;
      tool_y     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (take_load) begin
        state      <= ST_DIFF;
        seg_motion <= it.motion;
        pending    <= 1'b1;
      end else if (take_tick) begin
        tool_x <= tool_x_next;
        tool_y <= tool_y_next;
        if (arc) begin
          quad <= q_after;
        end
        if (done) begin
          seg_motion <= pcla_pkg::MOT_NONE;
          pending    <= 1'b1;
        end else begin
          if (arc) begin
            pending <= 1'b0;
          end
          if (wrap) begin
            state <= ST_DIFF;
          end
        end
      end else begin
        unique case (state)
          ST_DIFF: state <= ST_MUL;
          ST_MUL:  state <= ST_SUM;
          ST_SUM:  state <= ST_RUN;
          default: state <= ST_RUN;
        endcase
      end
      if (take_tick) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_load) begin
      ref_x <= (it.motion == pcla_pkg::MOT_LINE) ? ld_sx : ld_cx;
      ref_y <= (it.motion == pcla_pkg::MOT_LINE) ? ld_sy : ld_cy;
      end_x <= W'(it.end_x);
      end_y <= W'(it.end_y);
      xpr   <= ld_cx + ld_r;
      xmr   <= ld_cx - ld_r;
      ypr   <= ld_cy + ld_r;
      ymr   <= ld_cy - ld_r;
      dx    <= DW'(it.end_x) - DW'(it.start_x);
      dy    <= DW'(it.end_y) - DW'(it.start_y);
      ci    <= it.center_dx;
      cj    <= it.center_dy;
      r     <= it.radius;
    end
    unique case (state)
      ST_DIFF: begin
        u <= W'(tool_x) - ref_x;
        v <= W'(tool_y) - ref_y;
      end
      ST_MUL: begin
        p1 <= mul_a * mul_b;
        p2 <= mul_c * mul_d;
        p3 <= r * r;
      end
      ST_SUM: begin
        if (arc) f <= FW'(p1) + FW'(p2) - FW'(signed'({1'b0, p3}));
        else     f <= FW'(p1) - FW'(p2);
      end
      default: begin
        if (take_tick) begin
          u <= u + W'(step_x);
          v <= v + W'(step_y);
          f <= f + addend;
        end
      end
    endcase
    if (take_tick) begin
      m_tdata <= {4'b0000, step_y, step_x, pos_y_ext[15:0], pos_x_ext[15:0]};
      m_tlast <= done;
    end
  end

endmodule

>>> sv/point_compare_line_arc_interpolator_unit.sv
// ----------------------------------------------------------------------------
// point_compare_line_arc_interpolator_unit: point-by-point comparison
// interpolator for lines and circular arcs
// Loads a segment, then moves the tool one unit step per tick request.
// ----------------------------------------------------------------------------
// Tick requests are taken at one per clock cycle while the result side
// keeps up and the core is not setting up; each tick gives one result, by
// way of the queue entry and the result register. A load gives no result:
// the core latches the segment, then sets up the deviation from the current
// tool position in a difference, a multiply and a sum step. A tick that
// carries the tool across the end of the coordinate range, unless it ends
// the segment, is followed by the same set-up. A two-entry request queue
// lets new requests in while the core is busy; the result register lets
// loads and set-up go on while a result waits, but ticks wait until it is taken.
module point_compare_line_arc_interpolator_unit #(
  parameter int COORD_BITS = pcla_pkg::COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // motion, start_x, start_y, end_x, end_y, center_dx, center_dy, radius, zero fill
  input  logic [pcla_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pos_x, pos_y, step_x, step_y, zero fill
  output logic [pcla_pkg::OUT_DATA_W-1:0] m_tdata,
  // segment_done
  output logic                            m_tlast
);

  logic            q_valid;
  logic            q_pop;
  pcla_pkg::item_t q_item;

  pcla_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pcla_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
